FILE: src/stws_pkg.sv
package stws_pkg;

  localparam int WEIGHT_BITS = 16;
  localparam int RAND_BITS   = 16;
  localparam int ID_BITS     = 10;
  localparam int DRAW_BITS   = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [ID_BITS-1:0]     particle_id;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RAND_BITS-1:0]   rand_fraction;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0]     chosen_id;
    logic [WEIGHT_BITS-1:0] chosen_weight;
    logic [DRAW_BITS-1:0]   draw_number;
    logic [DRAW_BITS-1:0]   best_draw;
    logic                   empty_set;
  } out_item_t;

  typedef enum logic [16:0] {
    ST_IDLE = 17'b00000000000000001,
    ST_P0   = 17'b00000000000000010,
    ST_P1   = 17'b00000000000000100,
    ST_P2   = 17'b00000000000001000,
    ST_H0   = 17'b00000000000010000,
    ST_H1   = 17'b00000000000100000,
    ST_H2   = 17'b00000000001000000,
    ST_S0   = 17'b00000000010000000,
    ST_S1   = 17'b00000000100000000,
    ST_S2   = 17'b00000001000000000,
    ST_S3   = 17'b00000010000000000,
    ST_S4   = 17'b00000100000000000,
    ST_D0   = 17'b00001000000000000,
    ST_D1   = 17'b00010000000000000,
    ST_D2   = 17'b00100000000000000,
    ST_D3   = 17'b01000000000000000,
    ST_RES  = 17'b10000000000000000
  } state_t;

  typedef struct packed {
    state_t step;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic req_draw;
    logic req_last;
    logic sort;
    logic no_set;
    logic total_zero;
    logic node_zero;
    logic i_leaf;
    logic j_leaf;
    logic brk;
    logic off_tree;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

FILE: src/stws_ram.sv
module stws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/stws_ctrl.sv
module stws_ctrl import stws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.step   = state_r;
  assign cmd.accept = (state_r == ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.req_draw) begin
            state_nxt = ST_D0;
          end else if (sts.req_last) begin
            state_nxt = sts.sort ? ST_H0 : ST_P0;
          end
        end
      end
      ST_P0: state_nxt = ST_P1;
      ST_P1: state_nxt = ST_P2;
      ST_P2: state_nxt = sts.node_zero ? ST_IDLE : ST_P0;
      ST_H0: state_nxt = ST_H1;
      ST_H1: begin
        if (sts.i_leaf) begin
          state_nxt = sts.node_zero ? ST_IDLE : ST_H0;
        end else begin
          state_nxt = ST_H2;
        end
      end
      ST_H2: state_nxt = ST_S0;
      ST_S0: begin
        if (sts.j_leaf) begin
          state_nxt = sts.node_zero ? ST_IDLE : ST_H0;
        end else begin
          state_nxt = ST_S1;
        end
      end
      ST_S1: state_nxt = ST_S2;
      ST_S2: state_nxt = ST_S3;
      ST_S3: begin
        if (sts.brk) begin
          state_nxt = sts.node_zero ? ST_IDLE : ST_H0;
        end else begin
          state_nxt = ST_S4;
        end
      end
      ST_S4: state_nxt = ST_S0;
      ST_D0: state_nxt = sts.no_set ? ST_RES : ST_D1;
      ST_D1: state_nxt = sts.total_zero ? ST_RES : ST_D2;
      ST_D2: state_nxt = sts.off_tree ? ST_RES : ST_D3;
      ST_D3: state_nxt = sts.hit ? ST_RES : ST_D2;
      ST_RES: state_nxt = sts.out_free ? ST_IDLE : ST_RES;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/stws_dp.sv
module stws_dp import stws_pkg::*; #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  in_item_t  in_item,
  output out_item_t out_item,
  output logic      out_valid,
  input  logic      out_ready,
  input  cmd_t      cmd,
  output sts_t      sts
);

  localparam int IDXW = $clog2(MAX_PARTICLES);
  localparam int CNTW = $clog2(MAX_PARTICLES + 1);
  localparam int NW   = CNTW + 1;
  localparam int SUMW = WEIGHT_BITS + IDXW;

  logic [CNTW-1:0]        cnt_r;
  logic                   closed_r, sort_r;
  logic [DRAW_BITS-1:0]   dcnt_r, num_r, best_d_r;
  logic [WEIGHT_BITS-1:0] best_w_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic [NW-1:0]          i_r, j_r, nx_r;
  logic [SUMW-1:0]        sacc_r, t_r;
  logic [RAND_BITS-1:0]   rand_r;
  logic [WEIGHT_BITS-1:0] wj_r, wl_r, wnx_r, res_w_r;
  logic [ID_BITS-1:0]     idj_r, idl_r, res_id_r;
  logic                   res_empty_r;

  logic [WEIGHT_BITS-1:0] w_rd, w_wdata;
  logic [ID_BITS-1:0]     id_rd, id_wdata;
  logic [SUMW-1:0]        s_rd, s_wdata;
  logic                   w_we, s_we;
  logic [IDXW-1:0]        w_waddr, w_raddr, s_waddr, s_raddr;

  logic [NW:0]            m_ext, node_l, node_r, jl, jr, nx;
  logic [CNTW-1:0]        base, new_cnt;
  logic                   room, l_ok, r_ok, jr_ok, load_acc;
  logic                   brk, pick_r, go_left, hit;
  logic [WEIGHT_BITS-1:0] wnx;
  logic [ID_BITS-1:0]     idnx;
  logic [SUMW-1:0]        lw, diff, child_sum;
  logic [RAND_BITS+SUMW-1:0] prod;

  assign m_ext    = (NW+1)'(cnt_r);
  assign node_l   = {i_r, 1'b1};
  assign node_r   = {i_r, 1'b0} + (NW+1)'(2);
  assign jl       = {j_r, 1'b1};
  assign jr       = {j_r, 1'b0} + (NW+1)'(2);
  assign l_ok     = node_l < m_ext;
  assign r_ok     = node_r < m_ext;
  assign jr_ok    = jr < m_ext;
  assign base     = closed_r ? '0 : cnt_r;
  assign room     = base < CNTW'(MAX_PARTICLES);
  assign new_cnt  = base + CNTW'(room);
  assign load_acc = cmd.accept && (in_item.action == ACT_LOAD);

  // sift decision, right child weight comes straight from the ram
  always_comb begin
    pick_r = 1'b0;
    if (jr_ok) begin
      brk    = (wj_r >= wl_r) && (wj_r >= w_rd);
      pick_r = (wj_r < w_rd) && ((wj_r >= wl_r) || (w_rd > wl_r));
    end else begin
      brk = (wj_r >= wl_r);
    end
    nx   = pick_r ? jr : jl;
    wnx  = pick_r ? w_rd : wl_r;
    idnx = pick_r ? id_rd : idl_r;
  end

  assign lw        = l_ok ? s_rd : '0;
  assign go_left   = t_r < lw;
  assign diff      = t_r - lw;
  assign hit       = !go_left && (diff < SUMW'(w_rd));
  assign child_sum = sacc_r + (r_ok ? s_rd : '0);
  assign prod      = rand_r * s_rd;

  always_comb begin
    w_raddr = i_r[IDXW-1:0];
    case (cmd.step)
      ST_S0:   w_raddr = j_r[IDXW-1:0];
      ST_S1:   w_raddr = jl[IDXW-1:0];
      ST_S2:   w_raddr = jr[IDXW-1:0];
      default: w_raddr = i_r[IDXW-1:0];
    endcase
  end

  always_comb begin
    s_raddr = node_l[IDXW-1:0];
    case (cmd.step)
      ST_P1, ST_H1: s_raddr = node_r[IDXW-1:0];
      ST_S3:        s_raddr = nx[IDXW-1:0];
      ST_D0:        s_raddr = '0;
      default:      s_raddr = node_l[IDXW-1:0];
    endcase
  end

  always_comb begin
    w_we     = 1'b0;
    w_waddr  = base[IDXW-1:0];
    w_wdata  = in_item.weight;
    id_wdata = in_item.particle_id;
    if (load_acc) begin
      w_we = room;
    end else if (cmd.step == ST_S3) begin
      w_we     = !brk;
      w_waddr  = j_r[IDXW-1:0];
      w_wdata  = wnx;
      id_wdata = idnx;
    end else if (cmd.step == ST_S4) begin
      w_we     = 1'b1;
      w_waddr  = nx_r[IDXW-1:0];
      w_wdata  = wj_r;
      id_wdata = idj_r;
    end
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = i_r[IDXW-1:0];
    s_wdata = child_sum;
    case (cmd.step)
      ST_P2, ST_H2: s_we = 1'b1;
      ST_H1: begin
        s_we    = sts.i_leaf;
        s_wdata = SUMW'(w_rd);
      end
      ST_S4: begin
        s_we    = 1'b1;
        s_waddr = nx_r[IDXW-1:0];
        s_wdata = s_rd - (SUMW'(wnx_r) - SUMW'(wj_r));
      end
      default: s_we = 1'b0;
    endcase
  end

  stws_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_PARTICLES)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rd)
  );

  stws_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_PARTICLES)) u_iram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(id_wdata), .raddr(w_raddr), .rdata(id_rd)
  );

  stws_ram #(.WIDTH(SUMW), .DEPTH(MAX_PARTICLES)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rd)
  );

  assign sts.req_draw   = (in_item.action == ACT_DRAW);
  assign sts.req_last   = in_item.last;
  assign sts.sort       = sort_r;
  assign sts.no_set     = !closed_r || (cnt_r == '0);
  assign sts.total_zero = (s_rd == '0);
  assign sts.node_zero  = (i_r == '0);
  assign sts.i_leaf     = i_r >= NW'(cnt_r >> 1);
  assign sts.j_leaf     = j_r >= NW'(cnt_r >> 1);
  assign sts.brk        = brk;
  assign sts.off_tree   = i_r >= NW'(cnt_r);
  assign sts.hit        = hit;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      closed_r    <= 1'b0;
      sort_r      <= 1'b0;
      dcnt_r      <= '0;
      best_w_r    <= '0;
      best_d_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sort_r <= cfg_wr_data;
      end
      if (load_acc) begin
        cnt_r    <= new_cnt;
        closed_r <= in_item.last;
        dcnt_r   <= '0;
        best_w_r <= '0;
        best_d_r <= '0;
      end else if (cmd.accept) begin
        dcnt_r <= dcnt_r + DRAW_BITS'(1);
      end
      if ((cmd.step == ST_D3) && hit && (w_rd > best_w_r)) begin
        best_w_r <= w_rd;
        best_d_r <= num_r;
      end
      if ((cmd.step == ST_RES) && sts.out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      i_r <= NW'(new_cnt) - NW'(1);
    end else if (cmd.accept) begin
      num_r  <= dcnt_r;
      rand_r <= in_item.rand_fraction;
    end
    case (cmd.step)
      ST_P1: sacc_r <= SUMW'(w_rd) + (l_ok ? s_rd : '0);
      ST_P2: begin
        if (!sts.node_zero) begin
          i_r <= i_r - NW'(1);
        end
      end
      ST_H1: begin
        if (sts.i_leaf) begin
          if (!sts.node_zero) begin
            i_r <= i_r - NW'(1);
          end
        end else begin
          sacc_r <= SUMW'(w_rd) + s_rd;
        end
      end
      ST_H2: j_r <= i_r;
      ST_S0: begin
        if (sts.j_leaf && !sts.node_zero) begin
          i_r <= i_r - NW'(1);
        end
      end
      ST_S1: begin
        wj_r  <= w_rd;
        idj_r <= id_rd;
      end
      ST_S2: begin
        wl_r  <= w_rd;
        idl_r <= id_rd;
      end
      ST_S3: begin
        if (brk) begin
          if (!sts.node_zero) begin
            i_r <= i_r - NW'(1);
          end
        end else begin
          nx_r  <= nx[NW-1:0];
          wnx_r <= wnx;
        end
      end
      ST_S4: j_r <= nx_r;
      ST_D0: begin
        res_empty_r <= 1'b1;
        res_id_r    <= '0;
        res_w_r     <= '0;
      end
      ST_D1: begin
        t_r <= prod[RAND_BITS +: SUMW];
        i_r <= '0;
      end
      ST_D3: begin
        if (go_left) begin
          i_r <= node_l[NW-1:0];
        end else if (hit) begin
          res_empty_r <= 1'b0;
          res_id_r    <= id_rd;
          res_w_r     <= w_rd;
        end else begin
          t_r <= diff - SUMW'(w_rd);
          i_r <= node_r[NW-1:0];
        end
      end
      ST_RES: begin
        if (sts.out_free) begin
          out_r.chosen_id     <= res_id_r;
          out_r.chosen_weight <= res_w_r;
          out_r.draw_number   <= num_r;
          out_r.best_draw     <= best_d_r;
          out_r.empty_set     <= res_empty_r;
        end
      end
      default: ;
    endcase
  end

  a_res_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == ST_RES && sts.out_free) |=> out_valid_r)
    else $error("result not presented");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> (dcnt_r == '0) && (best_w_r == '0) && (best_d_r == '0))
    else $error("load did not clear draw history");

  a_swap_heavier: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == ST_S4) |-> (wnx_r > wj_r) && (nx_r > j_r))
    else $error("swap with a child that is not heavier");

  a_best_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == ST_D3 && hit) |=> best_w_r >= $past(w_rd))
    else $error("best weight not tracked");

endmodule

FILE: src/sum_tree_weighted_sampler.sv
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   in_item (in_item_t)
// out_     output     out_valid / out_ready out_item (out_item_t)
// cfg_     input      cfg_wr_en             cfg_wr_data (sort_on_build)
//
// a load request is taken while idle; the last one then builds the tree: plain
// via P0, P1, P2 per particle; in heap order H0, H1 per leaf, H0, H1, H2, S0 per
// inner node, S1 to S4 per swap, and S1 to S3 when the sift stops before a leaf
// a draw: D0, D1, then D2, D3 per tree level visited, one sum ram read per level
// reset (rst_n low, synchronous) empties the set and clears the draw history
// in_ready is low while a build or draw runs; a finished draw waits in the
// output register, and a new draw stalls only if that register is still full
module sum_tree_weighted_sampler import stws_pkg::*; #(
  parameter int MAX_PARTICLES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  cmd_t cmd;
  sts_t sts;

  stws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  stws_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_item(in_item), .out_item(out_item), .out_valid(out_valid),
    .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

endmodule
